>>> rtl/core/pbpq_pkg.sv
// Package for the power button press qualifier: transaction structs,
// configuration bundle, phase encoding and register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbpq_pkg;

	// Input transaction: one poll sample
	typedef struct packed {
		logic [11:0] sample_mv;
		logic [31:0] time_ms;
	} in_item_t;

	// Output transaction: one result per sample
	typedef struct packed {
		logic       shutdown;
		logic       toggle_pulse;
		logic [1:0] button_phase;
		logic       long_press_armed;
	} out_item_t;

	// Configuration registers as seen by the qualifier
	typedef struct packed {
		logic [11:0] press_threshold_mv;
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [15:0] click_window_ms;
	} cfg_t;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_PRESS_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE        = 2'd1;
	localparam logic [1:0] REG_LONG_PRESS      = 2'd2;
	localparam logic [1:0] REG_CLICK_WINDOW    = 2'd3;

	// Register reset values
	localparam logic [11:0] RST_PRESS_THRESHOLD = 12'd1000;
	localparam logic [15:0] RST_DEBOUNCE        = 16'd50;
	localparam logic [15:0] RST_LONG_PRESS      = 16'd3000;
	localparam logic [15:0] RST_CLICK_WINDOW    = 16'd400;

	// Button phase machine, one-hot
	typedef enum logic [3:0] {
		PH_IDLE        = 4'b0001,
		PH_DEB_PRESS   = 4'b0010,
		PH_PRESSED     = 4'b0100,
		PH_DEB_RELEASE = 4'b1000
	} phase_t;

	// Reported phase codes
	localparam logic [1:0] CODE_IDLE        = 2'd0;
	localparam logic [1:0] CODE_DEB_PRESS   = 2'd1;
	localparam logic [1:0] CODE_PRESSED     = 2'd2;
	localparam logic [1:0] CODE_DEB_RELEASE = 2'd3;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_IDLE:        code = CODE_IDLE;
			PH_DEB_PRESS:   code = CODE_DEB_PRESS;
			PH_PRESSED:     code = CODE_PRESSED;
			PH_DEB_RELEASE: code = CODE_DEB_RELEASE;
			default:        code = CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pbpq_cfg_regs.sv
// APB-style configuration registers for the press qualifier.
// Depends on pbpq_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none

module pbpq_cfg_regs
	import pbpq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold_mv <= RST_PRESS_THRESHOLD;
			cfg_q.debounce_ms        <= RST_DEBOUNCE;
			cfg_q.long_press_ms      <= RST_LONG_PRESS;
			cfg_q.click_window_ms    <= RST_CLICK_WINDOW;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PRESS_THRESHOLD: cfg_q.press_threshold_mv <= pwdata[11:0];
				REG_DEBOUNCE:        cfg_q.debounce_ms        <= pwdata[15:0];
				REG_LONG_PRESS:      cfg_q.long_press_ms      <= pwdata[15:0];
				REG_CLICK_WINDOW:    cfg_q.click_window_ms    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_PRESS_THRESHOLD: prdata = {20'd0, cfg_q.press_threshold_mv};
			REG_DEBOUNCE:        prdata = {16'd0, cfg_q.debounce_ms};
			REG_LONG_PRESS:      prdata = {16'd0, cfg_q.long_press_ms};
			REG_CLICK_WINDOW:    prdata = {16'd0, cfg_q.click_window_ms};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/pbpq_fsm.sv
// Button phase machine: debounce, long press, click counting and shutdown latch.
// Depends on pbpq_pkg (in_item_t, out_item_t, cfg_t, phase_t).
`timescale 1ns / 1ps
`default_nettype none

module pbpq_fsm
	import pbpq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire cfg_t      cfg,
	output out_item_t      result
);

	phase_t      phase_q,            phase_d;
	logic [31:0] phase_entered_q,    phase_entered_d;
	logic [31:0] press_began_q,      press_began_d;
	logic        armed_q,            armed_d;
	logic [31:0] last_release_q,     last_release_d;
	logic [1:0]  clicks_q,           clicks_d;
	logic        shutdown_q,         shutdown_d;
	logic        toggle;

	logic        pressed;
	logic [31:0] since_phase;
	logic [31:0] since_press;
	logic [31:0] since_release;
	logic        debounced;
	logic        short_hold;
	logic        in_window;
	logic [1:0]  clicks_inc;

	// Wrapping spans against the stored timestamps
	assign pressed       = item.sample_mv < cfg.press_threshold_mv;
	assign since_phase   = item.time_ms - phase_entered_q;
	assign since_press   = item.time_ms - press_began_q;
	assign since_release = item.time_ms - last_release_q;
	assign debounced     = since_phase >= {16'd0, cfg.debounce_ms};
	assign short_hold    = since_press < {16'd0, cfg.long_press_ms};
	assign in_window     = since_release <= {16'd0, cfg.click_window_ms};
	assign clicks_inc    = in_window ? clicks_q + 2'd1 : 2'd1;

	// Next-state logic
	always_comb begin
		phase_d         = phase_q;
		phase_entered_d = phase_entered_q;
		press_began_d   = press_began_q;
		armed_d         = armed_q;
		last_release_d  = last_release_q;
		clicks_d        = clicks_q;
		shutdown_d      = shutdown_q;
		toggle          = 1'b0;
		if (!shutdown_q) begin
			case (phase_q)
				PH_IDLE: begin
					if (pressed) begin
						phase_d         = PH_DEB_PRESS;
						phase_entered_d = item.time_ms;
					end else begin
						armed_d = 1'b1;
					end
				end
				PH_DEB_PRESS: begin
					if (!pressed) begin
						phase_d = PH_IDLE;
					end else if (debounced) begin
						if (!armed_q) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d       = PH_PRESSED;
							press_began_d = item.time_ms;
						end
					end
				end
				PH_PRESSED: begin
					if (!pressed) begin
						phase_d         = PH_DEB_RELEASE;
						phase_entered_d = item.time_ms;
					end else if (!short_hold) begin
						shutdown_d = 1'b1;
					end
				end
				PH_DEB_RELEASE: begin
					if (pressed) begin
						phase_d = PH_PRESSED;
					end else if (debounced) begin
						// short hold counts as a click; two within the click window toggle
						if (short_hold) begin
							last_release_d = item.time_ms;
							if (clicks_inc >= 2'd2) begin
								clicks_d = 2'd0;
								toggle   = 1'b1;
							end else begin
								clicks_d = clicks_inc;
							end
						end
						phase_d       = PH_IDLE;
						press_began_d = 32'd0;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// State registers, updated once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			phase_entered_q <= 32'd0;
			press_began_q   <= 32'd0;
			armed_q         <= 1'b0;
			last_release_q  <= 32'd0;
			clicks_q        <= 2'd0;
			shutdown_q      <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_d;
			phase_entered_q <= phase_entered_d;
			press_began_q   <= press_began_d;
			armed_q         <= armed_d;
			last_release_q  <= last_release_d;
			clicks_q        <= clicks_d;
			shutdown_q      <= shutdown_d;
		end
	end

	// Result reflects the state after this sample
	always_comb begin
		result.shutdown         = shutdown_d;
		result.toggle_pulse     = toggle;
		result.button_phase     = phase_code(phase_d);
		result.long_press_armed = armed_d;
	end

endmodule

`default_nettype wire

>>> rtl/core/power_button_press_qualifier.sv
// Top level of the power button press qualifier.
// Depends on pbpq_pkg, pbpq_cfg_regs and pbpq_fsm.
// Accepts one sample per clock cycle while out_ready does not stall the result register
// and returns one result per sample. A sample is captured in an input register, passes
// the phase machine when the result register can load, and its result is written to
// the output register, where it is held until taken. Throughput is one transaction per
// cycle while the output is not stalled; the output register lets a new sample enter
// while a result still waits. Write the configuration registers only while no
// transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module power_button_press_qualifier
	import pbpq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t result_s2;
	logic      valid_s2;
	logic      load_s2;
	logic      load_s1;

	pbpq_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: stage 2 loads when empty or drained
	assign load_s2  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | load_s2;
	assign load_s1  = in_valid & in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_data;
		end
	end

	pbpq_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load_s2),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

`default_nettype wire

>>> bench/tb_power_button_press_qualifier.sv
// Testbench for the power button press qualifier: directed table, then random
// press/release sequences checked against a behavioral predictor.
// Depends on pbpq_pkg and power_button_press_qualifier.
`timescale 1ns / 1ps

module tb_power_button_press_qualifier;
	import pbpq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_DIRECTED  = 25;
	localparam int N_SETTINGS  = 8;
	localparam int PHASE_ITEMS = 90;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	power_button_press_qualifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of the qualifier state and registers
	logic [11:0] cfg_thr  = RST_PRESS_THRESHOLD;
	logic [15:0] cfg_deb  = RST_DEBOUNCE;
	logic [15:0] cfg_long = RST_LONG_PRESS;
	logic [15:0] cfg_win  = RST_CLICK_WINDOW;
	logic [1:0]  qp_phase       = CODE_IDLE;
	logic [31:0] qp_entered_ms  = '0;
	logic [31:0] qp_press_ms    = '0;
	logic        qp_armed       = 1'b0;
	logic [31:0] qp_last_rel_ms = '0;
	logic [1:0]  qp_clicks      = '0;
	logic        qp_shut        = 1'b0;

	out_item_t pending_results[$];

	int n_samples  = 0;
	int n_results  = 0;
	int n_toggles  = 0;
	int n_settings = 0;
	int n_errors   = 0;
	int n_cycles   = 0;

	// Idling controls
	int src_idle    = 0;
	int snk_stall   = 0;
	int hold_req_cnt = 0;

	// Random sequence shaping
	logic        gen_level    = 1'b0;
	int          gen_run      = 0;
	int          gen_step     = 1;
	int          gen_step_max = 1;
	logic [31:0] gen_t        = '0;

	// Register settings walked by the random part
	int set_thr  [N_SETTINGS] = '{2048, 4095, 0,   1500, 3000,  800,   1000, 2500};
	int set_deb  [N_SETTINGS] = '{0,    65535, 10, 20,   0,     5,     50,   100};
	int set_long [N_SETTINGS] = '{1,    65535, 100, 500, 200,   65535, 3000, 1000};
	int set_win  [N_SETTINGS] = '{0,    65535, 50,  300, 65535, 100,   400,  0};

	// One step of the phase machine; returns the result of this sample
	function automatic out_item_t qualify_sample(in_item_t s);
		logic        pressed;
		logic        tog;
		logic [31:0] now;
		out_item_t   r;
		now     = s.time_ms;
		pressed = (s.sample_mv < cfg_thr);
		tog     = 1'b0;
		if (!qp_shut) begin
			case (qp_phase)
				CODE_IDLE: begin
					if (pressed) begin
						qp_phase      = CODE_DEB_PRESS;
						qp_entered_ms = now;
					end else begin
						qp_armed = 1'b1;
					end
				end
				CODE_DEB_PRESS: begin
					if (!pressed) begin
						qp_phase = CODE_IDLE;
					end else if ((now - qp_entered_ms) >= cfg_deb) begin
						// a press confirmed before arming does not start timing
						if (!qp_armed) begin
							qp_phase = CODE_IDLE;
						end else begin
							qp_phase    = CODE_PRESSED;
							qp_press_ms = now;
						end
					end
				end
				CODE_PRESSED: begin
					if (!pressed) begin
						qp_phase      = CODE_DEB_RELEASE;
						qp_entered_ms = now;
					end else if ((now - qp_press_ms) >= cfg_long) begin
						qp_shut = 1'b1;
					end
				end
				default: begin
					if (pressed) begin
						qp_phase = CODE_PRESSED;
					end else if ((now - qp_entered_ms) >= cfg_deb) begin
						// only short holds count as clicks
						if ((now - qp_press_ms) < cfg_long) begin
							if ((now - qp_last_rel_ms) <= cfg_win)
								qp_clicks = qp_clicks + 2'd1;
							else
								qp_clicks = 2'd1;
							qp_last_rel_ms = now;
							if (qp_clicks >= 2'd2) begin
								qp_clicks = 2'd0;
								tog       = 1'b1;
							end
						end
						qp_phase    = CODE_IDLE;
						qp_press_ms = '0;
					end
				end
			endcase
		end
		r.shutdown         = qp_shut;
		r.toggle_pulse     = tog;
		r.button_phase     = qp_phase;
		r.long_press_armed = qp_armed;
		return r;
	endfunction

	function automatic logic [11:0] released_mv();
		return 12'($urandom_range(4095, int'(cfg_thr)));
	endfunction

	// Next random sample: runs of one level with glitches and some noise
	function automatic in_item_t gen_sample(bit allow_shut);
		in_item_t    s;
		logic        want;
		logic [31:0] span;
		if (gen_run == 0) begin
			gen_level = ~gen_level;
			gen_run   = $urandom_range(6, 1);
			gen_step  = $urandom_range(gen_step_max, 1);
		end
		gen_run--;
		if ($urandom_range(99) < 4) begin
			s.time_ms   = $urandom();
			s.sample_mv = 12'($urandom_range(4095, 0));
		end else begin
			gen_t     = gen_t + $urandom_range(gen_step, 0);
			s.time_ms = gen_t;
			want      = gen_level ^ ($urandom_range(99) < 8);
			if (want && cfg_thr != 0)
				s.sample_mv = 12'($urandom_range(int'(cfg_thr) - 1, 0));
			else
				s.sample_mv = released_mv();
		end
		// keep clear of the long-press latch until the last phase
		span = s.time_ms - qp_press_ms;
		if (!allow_shut && qp_phase == CODE_PRESSED && s.sample_mv < cfg_thr
				&& span >= cfg_long)
			s.sample_mv = released_mv();
		return s;
	endfunction

	// Offer one sample, wait for it to be taken, then record its result
	task automatic send_sample(in_item_t s, bit known, out_item_t fixed_res);
		logic      acc;
		out_item_t pr;
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		acc = 1'b0;
		while (!acc) begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end
		pr = qualify_sample(s);
		pending_results.push_back(known ? fixed_res : pr);
		n_samples++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PRESS_THRESHOLD: cfg_thr  = val[11:0];
			REG_DEBOUNCE:        cfg_deb  = val[15:0];
			REG_LONG_PRESS:      cfg_long = val[15:0];
			default:             cfg_win  = val[15:0];
		endcase
	endtask

	task automatic write_setting(int thr, int deb, int lng, int win);
		apb_write(REG_PRESS_THRESHOLD, 32'(thr));
		apb_write(REG_DEBOUNCE, 32'(deb));
		apb_write(REG_LONG_PRESS, 32'(lng));
		apb_write(REG_CLICK_WINDOW, 32'(win));
		n_settings++;
		gen_run      = 0;
		gen_step_max = (deb + win) / 4 + 2;
	endtask

	// Directed stimulus table
	typedef struct packed {
		logic [11:0] mv;
		logic [31:0] t;
		logic        known;
		out_item_t   res;
	} drow_t;

	drow_t dir_rows [N_DIRECTED];

	function automatic drow_t row(logic [11:0] mv, logic [31:0] t);
		drow_t d;
		d.mv    = mv;
		d.t     = t;
		d.known = 1'b0;
		d.res   = '0;
		return d;
	endfunction

	function automatic drow_t row_k(logic [11:0] mv, logic [31:0] t, logic shut,
			logic tog, logic [1:0] ph, logic arm);
		drow_t d;
		d.mv    = mv;
		d.t     = t;
		d.known = 1'b1;
		d.res   = {shut, tog, ph, arm};
		return d;
	endfunction

	// Receiver: random stalls plus an occasional long hold-off
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_seen != hold_req_cnt) begin
			hold_seen = hold_req_cnt;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_stall);
		end
	end

	task automatic check_field(string name, logic [1:0] e, logic [1:0] a);
		if (e !== a) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, e, a);
			n_errors++;
		end
	endtask

	// Result checker; outputs are stable at the falling edge
	always @(negedge clk) begin
		out_item_t exp_r;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result %p", $time, out_data);
				n_errors++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("shutdown", 2'(exp_r.shutdown), 2'(out_data.shutdown));
				check_field("toggle_pulse", 2'(exp_r.toggle_pulse),
					2'(out_data.toggle_pulse));
				check_field("button_phase", exp_r.button_phase, out_data.button_phase);
				check_field("long_press_armed", 2'(exp_r.long_press_armed),
					2'(out_data.long_press_armed));
				n_results++;
				if (out_data.toggle_pulse === 1'b1)
					n_toggles++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("FAIL power_button_press_qualifier");
			$finish;
		end
	end

	initial begin
		in_item_t s;
		dir_rows = '{
			// first press before arming: timed, then dropped back to idle
			row_k(12'd0,    32'd0,   1'b0, 1'b0, CODE_DEB_PRESS, 1'b0),
			row_k(12'd0,    32'd50,  1'b0, 1'b0, CODE_IDLE, 1'b0),
			row_k(12'd4095, 32'd60,  1'b0, 1'b0, CODE_IDLE, 1'b1),
			// press glitch at the threshold value itself
			row(12'd999,    32'd100),
			row_k(12'd1000, 32'd120, 1'b0, 1'b0, CODE_IDLE, 1'b1),
			row(12'd0,      32'd200),
			row(12'd0,      32'd250),
			// release glitch returns to pressed
			row(12'd4095,   32'd260),
			row(12'd0,      32'd270),
			row(12'd4095,   32'd280),
			// first click near time zero, then a second one: toggle
			row(12'd4095,   32'd330),
			row(12'd0,      32'd400),
			row(12'd0,      32'd450),
			row(12'd4095,   32'd460),
			row_k(12'd4095, 32'd510, 1'b0, 1'b1, CODE_IDLE, 1'b1),
			// release after a long hold is not a click
			row(12'd0,      32'd600),
			row(12'd0,      32'd650),
			row(12'd4095,   32'd3700),
			row(12'd4095,   32'd3750),
			// timestamp wrap through the debounce and the hold
			row(12'd0,      32'hFFFF_FFFF),
			row(12'd0,      32'h0000_0031),
			row(12'd4095,   32'h0000_0040),
			row(12'd0,      32'h0000_0050),
			row(12'd0,      32'h0000_0BE8),
			row(12'd4095,   32'h0000_0BF0)
		};

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings
		foreach (dir_rows[i]) begin
			s.sample_mv = dir_rows[i].mv;
			s.time_ms   = dir_rows[i].t;
			send_sample(s, dir_rows[i].known, dir_rows[i].res);
		end
		wait_drained();

		// Random part: one phase per register setting, rotating idle patterns
		for (int k = 0; k < N_SETTINGS; k++) begin
			write_setting(set_thr[k], set_deb[k], set_long[k], set_win[k]);
			case (k % 4)
				0: begin src_idle = 0;  snk_stall = 0;  end
				1: begin src_idle = 49; snk_stall = 0;  end
				2: begin src_idle = 0;  snk_stall = 49; end
				default: begin src_idle = 29; snk_stall = 29; end
			endcase
			if (k == 0 || k == 5)
				hold_req_cnt++;
			gen_t = (k == 3) ? 32'hFFFF_F000 : $urandom();
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				if (j == PHASE_ITEMS / 2)
					wait_drained();
				send_sample(gen_sample(1'b0), 1'b0, '0);
			end
			wait_drained();
		end

		// Last phase: a held press reaches shutdown, then the state is frozen
		write_setting(2000, 10, 300, 200);
		src_idle  = 29;
		snk_stall = 29;
		for (int j = 0; j < 45; j++) begin
			if (j >= 20 && j < 35) begin
				gen_t       = gen_t + 32'd40;
				s.time_ms   = gen_t;
				s.sample_mv = 12'($urandom_range(1999, 0));
			end else begin
				s = gen_sample(1'b1);
			end
			send_sample(s, 1'b0, '0);
		end
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Ran %0d samples (%0d results checked) over %0d register settings;",
			n_samples, n_results, n_settings);
		$display("saw %0d double-click toggles, shutdown latched: %0d, mismatches: %0d",
			n_toggles, qp_shut, n_errors);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("PASS power_button_press_qualifier");
		end else begin
			$display("FAIL power_button_press_qualifier");
		end
		$finish;
	end

endmodule
